### rtl/nmgga_pkg.sv
// Package with the shared constants and record type of the GGA position extractor.
`timescale 1ns / 1ps

package nmgga_pkg;

    localparam int LAT_WIDTH  = 30;
    localparam int LON_WIDTH  = 34;
    localparam int HEMI_WIDTH = 8;
    localparam int ALT_WIDTH  = 18;
    localparam int MAG_WIDTH  = 17;
    localparam int REC_WIDTH  = LAT_WIDTH + HEMI_WIDTH + LON_WIDTH + HEMI_WIDTH + ALT_WIDTH;
    localparam int TDATA_OUT_WIDTH = ((REC_WIDTH + 7) / 8) * 8;

    localparam int LAT_DIGITS_DEFAULT = 9;
    localparam int LON_DIGITS_DEFAULT = 10;

    localparam logic [15:0] TALKER_RESET = 16'h474E;
    localparam logic [19:0] ALT_LIMIT    = 20'd99999;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_G      = 8'h47;
    localparam logic [7:0] CHAR_A      = 8'h41;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_0      = 8'h30;
    localparam logic [7:0] CHAR_9      = 8'h39;

    localparam logic [3:0] FIELD_LAT      = 4'd1;
    localparam logic [3:0] FIELD_LAT_HEMI = 4'd2;
    localparam logic [3:0] FIELD_LON      = 4'd3;
    localparam logic [3:0] FIELD_LON_HEMI = 4'd4;
    localparam logic [3:0] FIELD_ALT      = 4'd8;

    typedef struct packed {
        logic signed [ALT_WIDTH-1:0]  altitude;
        logic        [HEMI_WIDTH-1:0] lon_hemisphere;
        logic        [LON_WIDTH-1:0]  longitude;
        logic        [HEMI_WIDTH-1:0] lat_hemisphere;
        logic        [LAT_WIDTH-1:0]  latitude;
    } gga_rec_t;

endpackage

### rtl/nmgga_parser.sv
// Sentence state and field collection for one received byte per step.
`timescale 1ns / 1ps

module nmgga_parser #(
    parameter int LAT_DIGITS = nmgga_pkg::LAT_DIGITS_DEFAULT,
    parameter int LON_DIGITS = nmgga_pkg::LON_DIGITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         rx_byte,
    input  logic [15:0]        talker_id,
    output logic               rec_valid,
    output nmgga_pkg::gga_rec_t rec
);
    import nmgga_pkg::*;

    typedef enum logic [7:0] {
        HDR_IDLE   = 8'b0000_0001,
        HDR_DOLLAR = 8'b0000_0010,
        HDR_TALK1  = 8'b0000_0100,
        HDR_TALK2  = 8'b0000_1000,
        HDR_G1     = 8'b0001_0000,
        HDR_G2     = 8'b0010_0000,
        HDR_A      = 8'b0100_0000,
        HDR_DATA   = 8'b1000_0000
    } hdr_state_t;

    hdr_state_t             hdr_reg, hdr_next;
    logic [3:0]             field_reg, field_next;
    logic [LAT_WIDTH-1:0]   lat_reg, lat_next;
    logic [LON_WIDTH-1:0]   lon_reg, lon_next;
    logic [HEMI_WIDTH-1:0]  lat_hemi_reg, lat_hemi_next;
    logic [HEMI_WIDTH-1:0]  lon_hemi_reg, lon_hemi_next;
    logic [MAG_WIDTH-1:0]   alt_reg, alt_next;
    logic                   alt_neg_reg, alt_neg_next;
    logic                   alt_frac_reg, alt_frac_next;
    logic [3:0]             digit_cnt_reg, digit_cnt_next;

    logic                   is_digit;
    logic                   ends;
    logic [3:0]             digit_val;
    logic [LAT_WIDTH-1:0]   lat_step;
    logic [LON_WIDTH-1:0]   lon_step;
    logic [19:0]            alt_step;
    logic [ALT_WIDTH-1:0]   alt_mag;

    assign is_digit  = (rx_byte >= CHAR_0) && (rx_byte <= CHAR_9);
    assign ends      = (rx_byte == CHAR_COMMA) || (rx_byte == CHAR_STAR)
                    || (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
    assign digit_val = rx_byte[3:0];

    assign lat_step = {lat_reg[LAT_WIDTH-4:0], 3'b000} + {lat_reg[LAT_WIDTH-2:0], 1'b0}
                    + {{(LAT_WIDTH-4){1'b0}}, digit_val};
    assign lon_step = {lon_reg[LON_WIDTH-4:0], 3'b000} + {lon_reg[LON_WIDTH-2:0], 1'b0}
                    + {{(LON_WIDTH-4){1'b0}}, digit_val};
    assign alt_step = {alt_reg, 3'b000} + {2'b00, alt_reg, 1'b0} + {16'd0, digit_val};

    assign alt_mag = {1'b0, alt_reg};

    always_comb
    begin
        rec.latitude       = lat_reg;
        rec.lat_hemisphere = lat_hemi_reg;
        rec.longitude      = lon_reg;
        rec.lon_hemisphere = lon_hemi_reg;
        rec.altitude       = alt_neg_reg ? -alt_mag : alt_mag;
    end

    always_comb
    begin
        hdr_next       = hdr_reg;
        field_next     = field_reg;
        lat_next       = lat_reg;
        lon_next       = lon_reg;
        lat_hemi_next  = lat_hemi_reg;
        lon_hemi_next  = lon_hemi_reg;
        alt_next       = alt_reg;
        alt_neg_next   = alt_neg_reg;
        alt_frac_next  = alt_frac_reg;
        digit_cnt_next = digit_cnt_reg;
        rec_valid      = 1'b0;

        if (step)
        begin
            if (rx_byte == CHAR_DOLLAR)
            begin
                hdr_next       = HDR_DOLLAR;
                field_next     = '0;
                lat_next       = '0;
                lon_next       = '0;
                lat_hemi_next  = '0;
                lon_hemi_next  = '0;
                alt_next       = '0;
                alt_neg_next   = 1'b0;
                alt_frac_next  = 1'b0;
                digit_cnt_next = '0;
            end
            else
            begin
                unique case (hdr_reg)
                    HDR_IDLE:   hdr_next = HDR_IDLE;
                    HDR_DOLLAR: hdr_next = (rx_byte == talker_id[15:8]) ? HDR_TALK1 : HDR_IDLE;
                    HDR_TALK1:  hdr_next = (rx_byte == talker_id[7:0]) ? HDR_TALK2 : HDR_IDLE;
                    HDR_TALK2:  hdr_next = (rx_byte == CHAR_G) ? HDR_G1 : HDR_IDLE;
                    HDR_G1:     hdr_next = (rx_byte == CHAR_G) ? HDR_G2 : HDR_IDLE;
                    HDR_G2:     hdr_next = (rx_byte == CHAR_A) ? HDR_A : HDR_IDLE;
                    HDR_A:      hdr_next = (rx_byte == CHAR_COMMA) ? HDR_DATA : HDR_IDLE;
                    HDR_DATA:
                    begin
                        if (ends)
                        begin
                            if (field_reg == FIELD_ALT)
                            begin
                                rec_valid = 1'b1;
                                hdr_next  = HDR_IDLE;
                            end
                            else if (rx_byte == CHAR_COMMA)
                            begin
                                field_next     = field_reg + 4'd1;
                                digit_cnt_next = '0;
                            end
                            else
                            begin
                                hdr_next = HDR_IDLE;
                            end
                        end
                        else
                        begin
                            unique case (field_reg)
                                FIELD_LAT:
                                begin
                                    if (is_digit && (digit_cnt_reg < 4'(LAT_DIGITS)))
                                    begin
                                        lat_next       = lat_step;
                                        digit_cnt_next = digit_cnt_reg + 4'd1;
                                    end
                                end
                                FIELD_LAT_HEMI:
                                begin
                                    if (digit_cnt_reg == '0)
                                    begin
                                        lat_hemi_next  = rx_byte;
                                        digit_cnt_next = 4'd1;
                                    end
                                end
                                FIELD_LON:
                                begin
                                    if (is_digit && (digit_cnt_reg < 4'(LON_DIGITS)))
                                    begin
                                        lon_next       = lon_step;
                                        digit_cnt_next = digit_cnt_reg + 4'd1;
                                    end
                                end
                                FIELD_LON_HEMI:
                                begin
                                    if (digit_cnt_reg == '0)
                                    begin
                                        lon_hemi_next  = rx_byte;
                                        digit_cnt_next = 4'd1;
                                    end
                                end
                                FIELD_ALT:
                                begin
                                    if (rx_byte == CHAR_DOT)
                                    begin
                                        alt_frac_next = 1'b1;
                                    end
                                    else if (rx_byte == CHAR_MINUS)
                                    begin
                                        if ((digit_cnt_reg == '0) && !alt_frac_reg)
                                        begin
                                            alt_neg_next = 1'b1;
                                        end
                                    end
                                    else if (is_digit && !alt_frac_reg)
                                    begin
                                        alt_next = (alt_step > ALT_LIMIT) ? ALT_LIMIT[MAG_WIDTH-1:0]
                                                                          : alt_step[MAG_WIDTH-1:0];
                                        if (digit_cnt_reg != 4'hF)
                                        begin
                                            digit_cnt_next = digit_cnt_reg + 4'd1;
                                        end
                                    end
                                end
                                default: field_next = field_reg;
                            endcase
                        end
                    end
                    default: hdr_next = HDR_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg       <= HDR_IDLE;
            field_reg     <= '0;
            lat_reg       <= '0;
            lon_reg       <= '0;
            lat_hemi_reg  <= '0;
            lon_hemi_reg  <= '0;
            alt_reg       <= '0;
            alt_neg_reg   <= 1'b0;
            alt_frac_reg  <= 1'b0;
            digit_cnt_reg <= '0;
        end
        else
        begin
            hdr_reg       <= hdr_next;
            field_reg     <= field_next;
            lat_reg       <= lat_next;
            lon_reg       <= lon_next;
            lat_hemi_reg  <= lat_hemi_next;
            lon_hemi_reg  <= lon_hemi_next;
            alt_reg       <= alt_next;
            alt_neg_reg   <= alt_neg_next;
            alt_frac_reg  <= alt_frac_next;
            digit_cnt_reg <= digit_cnt_next;
        end
    end

endmodule

### rtl/nmea_gga_position_extractor.sv
// Top level of the GGA position extractor: input register, parser and record register.
// A byte waits in the input register until the parser takes it; the record built from the byte
// that ends the altitude field is registered in the record register and offered on the master side.
// Throughput: one byte per cycle while the master side takes records; a record held in the record
// register by a stalled master side holds off input, once the input register is full, until taken.
// Reset clears the sentence state and both stages at once and loads the talker "GN".
`timescale 1ns / 1ps

module nmea_gga_position_extractor #(
    parameter int LAT_DIGITS = nmgga_pkg::LAT_DIGITS_DEFAULT,
    parameter int LON_DIGITS = nmgga_pkg::LON_DIGITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // from the LSB up: latitude, lat_hemisphere, longitude, lon_hemisphere, altitude, zero pad
    output logic [nmgga_pkg::TDATA_OUT_WIDTH-1:0] m_axis_tdata
);
    import nmgga_pkg::*;

    logic [15:0] talker_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg, out_valid_next;
    gga_rec_t    out_rec_reg;

    logic        advance;
    logic        rec_valid;
    gga_rec_t    rec;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    nmgga_parser #(
        .LAT_DIGITS(LAT_DIGITS),
        .LON_DIGITS(LON_DIGITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .talker_id (talker_reg),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && rec_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            talker_reg    <= TALKER_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                talker_reg <= cfg_wr_data;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance && rec_valid)
        begin
            out_rec_reg <= rec;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TDATA_OUT_WIDTH-REC_WIDTH){1'b0}}, out_rec_reg};

    // A record can only come from a byte that is actually being consumed.
    assert property (@(posedge clk) disable iff (!rst_n) rec_valid && advance |-> in_valid_reg)
        else $error("record produced without a buffered byte");

    // The input side must never stall while the record register is empty.
    assert property (@(posedge clk) disable iff (!rst_n) !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with an empty record register");

    // A full input register behind a stalled record register must hold off new transfers.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while both stages are full");

    // Saturation keeps the reported altitude within plus or minus 99999.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_rec_reg.altitude <= 18'sd99999)
                       && (out_rec_reg.altitude >= -18'sd99999))
        else $error("altitude outside its saturated range");

    // A completed record that is not taken stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(out_rec_reg))
        else $error("pending record lost or changed");

endmodule
